### design/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// WAV header parser package
// Shared result kinds, error codes, sample codings, chunk tags and the
// result record passed from the parsing core to the output stage.
// ----------------------------------------------------------------------------
package wavhp_pkg;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_FORMAT = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_BAD_TAG    = 3'd1,
		ERR_NO_FORMAT  = 3'd2,
		ERR_BAD_CODING = 3'd3,
		ERR_BAD_RATE   = 3'd4,
		ERR_EARLY_END  = 3'd5
	} err_t;

	typedef enum logic [1:0] {
		COD_FLOAT32 = 2'd0,
		COD_INT16   = 2'd1,
		COD_UINT8   = 2'd2,
		COD_INT32   = 2'd3
	} coding_t;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [15:0] FMT_TAG_PCM   = 16'd1;
	localparam logic [15:0] FMT_TAG_FLOAT = 16'd3;

	localparam int TDATA_W = 80;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [7:0]  sample_byte;
		logic        last;
		coding_t     sample_coding;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [15:0] bits_per_sample;
		err_t        error_code;
	} result_t;

endpackage

### design/wav_header_parser.sv
// A byte waits in the input register, its result, if any, in the result register.
// Throughput: one byte per cycle; the input register and the result register
// each advance whenever the result register is empty or being taken.
// Reset clears the parsing state and both valid flags at once; the parser
// then waits for byte 0 of a new file.
// ----------------------------------------------------------------------------
// WAV header parser
// Streams a WAV file in byte by byte, checks its RIFF/WAVE header and chunk
// structure, reports the format or an error, then forwards payload bytes.
// ----------------------------------------------------------------------------
module wav_header_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // in_byte
	input  logic                             s_tlast,  // end_of_file
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// sample_byte[7:0], sample_coding[9:8], channel_count[25:10],
	// sample_rate[57:26], bits_per_sample[73:58], error_code[76:74], zeros above
	output logic [wavhp_pkg::TDATA_W-1:0]    m_tdata,
	output logic                             m_tlast,  // last
	output logic [1:0]                       m_tuser   // kind
);
	import wavhp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       advance;
	result_t    res;
	result_t    res_s2;
	logic       valid_s2;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eof_s1  <= s_tlast;
		end
	end

	wavhp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.in_byte     (byte_s1),
		.end_of_file (eof_s1),
		.result      (res)
	);

	// A byte that causes no result still advances, leaving the result register empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = res_s2.last;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {3'b000, res_s2.error_code, res_s2.bits_per_sample,
	                   res_s2.sample_rate, res_s2.channel_count,
	                   res_s2.sample_coding, res_s2.sample_byte};

endmodule

### design/wavhp_core.sv
// ----------------------------------------------------------------------------
// WAV header parser core
// Holds the parsing state and works out the result for one file byte.
// The state advances only when step is high.
// ----------------------------------------------------------------------------
module wavhp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          in_byte,
	input  logic                end_of_file,
	output wavhp_pkg::result_t  result
);
	import wavhp_pkg::*;

	typedef enum logic [2:0] {
		PH_HDR  = 3'b001,
		PH_BODY = 3'b010,
		PH_PAY  = 3'b100
	} phase_t;

	logic [3:0]  header_count_q, header_count_d;
	phase_t      phase_q, phase_d;
	logic [31:0] chunk_tag_q, chunk_tag_d;
	logic [31:0] chunk_length_q, chunk_length_d;
	logic [32:0] body_left_q, body_left_d;
	logic [4:0]  field_count_q, field_count_d;
	logic [15:0] coding_word_q, coding_word_d;
	logic [15:0] channels_word_q, channels_word_d;
	logic [31:0] rate_word_q, rate_word_d;
	logic [15:0] bits_word_q, bits_word_d;
	logic        have_format_q, have_format_d;
	logic        capturing_q, capturing_d;
	logic [31:0] payload_left_q, payload_left_d;
	logic        finished_q, finished_d;

	always_comb begin
		result_t     res;
		logic [31:0] tag_sh;
		logic [4:0]  fc_inc;
		logic [32:0] bl_dec;
		logic [31:0] pl_dec;
		coding_t     cod;
		logic        cod_ok;

		header_count_d  = header_count_q;
		phase_d         = phase_q;
		chunk_tag_d     = chunk_tag_q;
		chunk_length_d  = chunk_length_q;
		body_left_d     = body_left_q;
		field_count_d   = field_count_q;
		coding_word_d   = coding_word_q;
		channels_word_d = channels_word_q;
		rate_word_d     = rate_word_q;
		bits_word_d     = bits_word_q;
		have_format_d   = have_format_q;
		capturing_d     = capturing_q;
		payload_left_d  = payload_left_q;
		finished_d      = finished_q;

		res        = '0;
		res.kind   = KIND_SAMPLE;
		tag_sh     = {chunk_tag_q[23:0], in_byte};
		fc_inc     = field_count_q + 5'd1;
		bl_dec     = body_left_q;
		pl_dec     = payload_left_q;
		cod        = COD_FLOAT32;
		cod_ok     = 1'b1;

		if (!finished_q) begin
			if (header_count_q < 4'd12) begin
				if (header_count_q < 4'd4 || header_count_q >= 4'd8)
					chunk_tag_d = tag_sh;
				if ((header_count_q == 4'd3 && tag_sh != TAG_RIFF) ||
				    (header_count_q == 4'd11 && tag_sh != TAG_WAVE)) begin
					res.valid      = 1'b1;
					res.kind       = KIND_ERROR;
					res.last       = 1'b1;
					res.error_code = ERR_BAD_TAG;
				end
				if (header_count_q == 4'd3 || header_count_q == 4'd11)
					chunk_tag_d = '0;
				header_count_d = header_count_q + 4'd1;
			end else begin
				unique case (phase_q)
					PH_BODY: begin
						if (capturing_q && field_count_q < 5'd16) begin
							unique case (field_count_q[3:0])
								4'd0:  coding_word_d[7:0]    = in_byte;
								4'd1:  coding_word_d[15:8]   = in_byte;
								4'd2:  channels_word_d[7:0]  = in_byte;
								4'd3:  channels_word_d[15:8] = in_byte;
								4'd4:  rate_word_d[7:0]      = in_byte;
								4'd5:  rate_word_d[15:8]     = in_byte;
								4'd6:  rate_word_d[23:16]    = in_byte;
								4'd7:  rate_word_d[31:24]    = in_byte;
								4'd14: bits_word_d[7:0]      = in_byte;
								4'd15: bits_word_d[15:8]     = in_byte;
								default: ;
							endcase
							field_count_d = fc_inc;
							if (fc_inc == 5'd16) begin
								have_format_d = 1'b1;
								capturing_d   = 1'b0;
							end
						end
						if (body_left_q != '0)
							bl_dec = body_left_q - 33'd1;
						body_left_d = bl_dec;
						if (bl_dec == '0) begin
							phase_d       = PH_HDR;
							field_count_d = '0;
							capturing_d   = 1'b0;
						end
					end
					PH_PAY: begin
						if (payload_left_q != '0)
							pl_dec = payload_left_q - 32'd1;
						payload_left_d  = pl_dec;
						res.valid       = 1'b1;
						res.kind        = KIND_SAMPLE;
						res.sample_byte = in_byte;
						res.last        = (pl_dec == '0) || end_of_file;
					end
					default: begin
						// Chunk header: four tag bytes, then a little-endian length.
						if (field_count_q < 5'd4) begin
							chunk_tag_d = tag_sh;
						end else if (field_count_q < 5'd8) begin
							unique case (field_count_q[1:0])
								2'd0: chunk_length_d[7:0]   = chunk_length_q[7:0] | in_byte;
								2'd1: chunk_length_d[15:8]  = chunk_length_q[15:8] | in_byte;
								2'd2: chunk_length_d[23:16] = chunk_length_q[23:16] | in_byte;
								default: chunk_length_d[31:24] =
									chunk_length_q[31:24] | in_byte;
							endcase
						end
						field_count_d = fc_inc;
						if (fc_inc >= 5'd8) begin
							field_count_d = '0;
							if (chunk_tag_d == TAG_DATA) begin
								if (coding_word_q == FMT_TAG_FLOAT && bits_word_q == 16'd32)
									cod = COD_FLOAT32;
								else if (coding_word_q == FMT_TAG_PCM && bits_word_q == 16'd16)
									cod = COD_INT16;
								else if (coding_word_q == FMT_TAG_PCM && bits_word_q == 16'd8)
									cod = COD_UINT8;
								else if (coding_word_q == FMT_TAG_PCM && bits_word_q == 16'd32)
									cod = COD_INT32;
								else
									cod_ok = 1'b0;
								res.valid = 1'b1;
								if (!have_format_q) begin
									res.kind       = KIND_ERROR;
									res.last       = 1'b1;
									res.error_code = ERR_NO_FORMAT;
								end else if (!cod_ok) begin
									res.kind       = KIND_ERROR;
									res.last       = 1'b1;
									res.error_code = ERR_BAD_CODING;
								end else if (channels_word_q == '0 || rate_word_q == '0 ||
								             rate_word_q[31]) begin
									res.kind       = KIND_ERROR;
									res.last       = 1'b1;
									res.error_code = ERR_BAD_RATE;
								end else begin
									payload_left_d      = chunk_length_d;
									res.kind            = KIND_FORMAT;
									res.last            = (chunk_length_d == '0) || end_of_file;
									res.sample_coding   = cod;
									res.channel_count   = channels_word_q;
									res.sample_rate     = rate_word_q;
									res.bits_per_sample = bits_word_q;
									phase_d             = PH_PAY;
								end
							end else begin
								capturing_d = (chunk_tag_d == TAG_FMT) &&
								              (chunk_length_d >= 32'd16);
								body_left_d = {1'b0, chunk_length_d} +
								              {32'd0, chunk_length_d[0]};
								chunk_tag_d    = '0;
								chunk_length_d = '0;
								phase_d = (body_left_d == '0) ? PH_HDR : PH_BODY;
							end
						end
					end
				endcase
			end

			if (end_of_file && !res.valid) begin
				res.valid      = 1'b1;
				res.kind       = KIND_ERROR;
				res.last       = 1'b1;
				res.error_code = ERR_EARLY_END;
			end
			if (res.valid && res.last)
				finished_d = 1'b1;
		end

		// The final byte of a file always leaves the parser fully cleared.
		if (end_of_file) begin
			header_count_d  = '0;
			phase_d         = PH_HDR;
			chunk_tag_d     = '0;
			chunk_length_d  = '0;
			body_left_d     = '0;
			field_count_d   = '0;
			coding_word_d   = '0;
			channels_word_d = '0;
			rate_word_d     = '0;
			bits_word_d     = '0;
			have_format_d   = 1'b0;
			capturing_d     = 1'b0;
			payload_left_d  = '0;
			finished_d      = 1'b0;
		end

		result = res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q  <= '0;
			phase_q         <= PH_HDR;
			chunk_tag_q     <= '0;
			chunk_length_q  <= '0;
			body_left_q     <= '0;
			field_count_q   <= '0;
			coding_word_q   <= '0;
			channels_word_q <= '0;
			rate_word_q     <= '0;
			bits_word_q     <= '0;
			have_format_q   <= 1'b0;
			capturing_q     <= 1'b0;
			payload_left_q  <= '0;
			finished_q      <= 1'b0;
		end else if (step) begin
			header_count_q  <= header_count_d;
			phase_q         <= phase_d;
			chunk_tag_q     <= chunk_tag_d;
			chunk_length_q  <= chunk_length_d;
			body_left_q     <= body_left_d;
			field_count_q   <= field_count_d;
			coding_word_q   <= coding_word_d;
			channels_word_q <= channels_word_d;
			rate_word_q     <= rate_word_d;
			bits_word_q     <= bits_word_d;
			have_format_q   <= have_format_d;
			capturing_q     <= capturing_d;
			payload_left_q  <= payload_left_d;
			finished_q      <= finished_d;
		end
	end

endmodule

### sim/wav_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV stream checker
// Follows every input transfer with a byte-level model of the RIFF/WAVE
// parser, queues the results that each byte should cause, and compares every
// output transfer field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module wav_stream_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [7:0]                    s_tdata,
	input  logic                          s_tlast,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [wavhp_pkg::TDATA_W-1:0] m_tdata,
	input  logic                          m_tlast,
	input  logic [1:0]                    m_tuser,
	output int                            pending_results,
	output int                            mismatch_count
);
	import wavhp_pkg::*;

	localparam logic [1:0] PH_CHUNK_HEADER = 2'd0;
	localparam logic [1:0] PH_BODY_SKIP    = 2'd1;
	localparam logic [1:0] PH_PAYLOAD      = 2'd2;
	localparam int         REPORT_LIMIT    = 10;

	// Parser state as the block should hold it
	logic [3:0]  hdr_bytes;
	logic [1:0]  phase;
	logic [31:0] tag_acc;
	logic [31:0] len_acc;
	logic [32:0] skip_left;
	logic [4:0]  field_idx;
	logic [15:0] fmt_coding;
	logic [15:0] fmt_channels;
	logic [31:0] fmt_rate;
	logic [15:0] fmt_bits;
	logic        fmt_kept;
	logic        fmt_capture;
	logic [31:0] payload_left;
	logic        file_done;

	result_t     expected_q[$];
	result_t     want;

	task automatic clear_parser();
		hdr_bytes    = '0;
		phase        = PH_CHUNK_HEADER;
		tag_acc      = '0;
		len_acc      = '0;
		skip_left    = '0;
		field_idx    = '0;
		fmt_coding   = '0;
		fmt_channels = '0;
		fmt_rate     = '0;
		fmt_bits     = '0;
		fmt_kept     = 1'b0;
		fmt_capture  = 1'b0;
		payload_left = '0;
		file_done    = 1'b0;
	endtask

	function automatic result_t error_result(err_t code);
		result_t r;
		r            = '0;
		r.valid      = 1'b1;
		r.kind       = KIND_ERROR;
		r.last       = 1'b1;
		r.error_code = code;
		return r;
	endfunction

	task automatic predict_byte(input logic [7:0] b, input logic eof);
		result_t r;
		coding_t coding;
		logic    coding_ok;
		r         = '0;
		coding    = COD_FLOAT32;
		coding_ok = 1'b1;
		if (file_done) begin
			// Only the final byte of a finished file matters: it rearms the parser.
			if (eof)
				clear_parser();
		end else begin
			if (hdr_bytes < 4'd12) begin
				// Bytes 4 to 7 hold the RIFF size, which is not checked.
				if (hdr_bytes < 4'd4 || hdr_bytes >= 4'd8)
					tag_acc = {tag_acc[23:0], b};
				if ((hdr_bytes == 4'd3 && tag_acc != TAG_RIFF) ||
				    (hdr_bytes == 4'd11 && tag_acc != TAG_WAVE))
					r = error_result(ERR_BAD_TAG);
				if (hdr_bytes == 4'd3 || hdr_bytes == 4'd11)
					tag_acc = '0;
				hdr_bytes = hdr_bytes + 4'd1;
			end else if (phase == PH_BODY_SKIP) begin
				if (fmt_capture && field_idx < 5'd16) begin
					case (field_idx)
						5'd0: fmt_coding[7:0] = b;
						5'd1: fmt_coding[15:8] = b;
						5'd2: fmt_channels[7:0] = b;
						5'd3: fmt_channels[15:8] = b;
						5'd4, 5'd5, 5'd6, 5'd7: fmt_rate[8 * (field_idx - 5'd4) +: 8] = b;
						5'd14: fmt_bits[7:0] = b;
						5'd15: fmt_bits[15:8] = b;
						default: ;
					endcase
					field_idx = field_idx + 5'd1;
					if (field_idx == 5'd16) begin
						fmt_kept    = 1'b1;
						fmt_capture = 1'b0;
					end
				end
				if (skip_left != '0)
					skip_left = skip_left - 33'd1;
				if (skip_left == '0) begin
					phase       = PH_CHUNK_HEADER;
					field_idx   = '0;
					fmt_capture = 1'b0;
				end
			end else if (phase == PH_PAYLOAD) begin
				if (payload_left != '0)
					payload_left = payload_left - 32'd1;
				r.valid       = 1'b1;
				r.kind        = KIND_SAMPLE;
				r.sample_byte = b;
				r.last        = (payload_left == '0) || eof;
			end else begin
				if (field_idx < 5'd4)
					tag_acc = {tag_acc[23:0], b};
				else
					len_acc[8 * (field_idx - 5'd4) +: 8] = b;
				field_idx = field_idx + 5'd1;
				if (field_idx == 5'd8) begin
					field_idx = '0;
					if (tag_acc == TAG_DATA) begin
						if (fmt_coding == FMT_TAG_FLOAT && fmt_bits == 16'd32)
							coding = COD_FLOAT32;
						else if (fmt_coding == FMT_TAG_PCM && fmt_bits == 16'd16)
							coding = COD_INT16;
						else if (fmt_coding == FMT_TAG_PCM && fmt_bits == 16'd8)
							coding = COD_UINT8;
						else if (fmt_coding == FMT_TAG_PCM && fmt_bits == 16'd32)
							coding = COD_INT32;
						else
							coding_ok = 1'b0;
						// The coding is judged before the channel count and the rate.
						if (!fmt_kept)
							r = error_result(ERR_NO_FORMAT);
						else if (!coding_ok)
							r = error_result(ERR_BAD_CODING);
						else if (fmt_channels == '0 || fmt_rate == '0 || fmt_rate[31])
							r = error_result(ERR_BAD_RATE);
						else begin
							r.valid           = 1'b1;
							r.kind            = KIND_FORMAT;
							r.last            = (len_acc == '0) || eof;
							r.sample_coding   = coding;
							r.channel_count   = fmt_channels;
							r.sample_rate     = fmt_rate;
							r.bits_per_sample = fmt_bits;
							payload_left      = len_acc;
							phase             = PH_PAYLOAD;
						end
					end else begin
						fmt_capture = (tag_acc == TAG_FMT) && (len_acc >= 32'd16);
						// An odd body is followed by one pad byte.
						skip_left   = {1'b0, len_acc} + {32'd0, len_acc[0]};
						tag_acc     = '0;
						len_acc     = '0;
						phase       = (skip_left == '0) ? PH_CHUNK_HEADER : PH_BODY_SKIP;
					end
				end
			end
			if (eof && !r.valid)
				r = error_result(ERR_EARLY_END);
			if (r.valid)
				expected_q.push_back(r);
			if (eof)
				clear_parser();
			else if (r.valid && r.last)
				file_done = 1'b1;
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
	                             input logic [31:0] exp_value);
		if (got !== exp_value) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: %s mismatch, expected %0h, got %0h",
				         $time, name, exp_value, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			expected_q.delete();
			pending_results <= 0;
			mismatch_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("%0t: result transfer with nothing expected, kind %0d data %0h",
						         $time, m_tuser, m_tdata);
				end else begin
					want = expected_q.pop_front();
					compare_field("kind", 32'(m_tuser), 32'(want.kind));
					compare_field("last", 32'(m_tlast), 32'(want.last));
					compare_field("sample_byte", 32'(m_tdata[7:0]), 32'(want.sample_byte));
					compare_field("sample_coding", 32'(m_tdata[9:8]),
					              32'(want.sample_coding));
					compare_field("channel_count", 32'(m_tdata[25:10]),
					              32'(want.channel_count));
					compare_field("sample_rate", m_tdata[57:26], want.sample_rate);
					compare_field("bits_per_sample", 32'(m_tdata[73:58]),
					              32'(want.bits_per_sample));
					compare_field("error_code", 32'(m_tdata[76:74]), 32'(want.error_code));
					compare_field("tdata padding", 32'(m_tdata[TDATA_W-1:77]), '0);
				end
			end
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tlast);
			pending_results <= expected_q.size();
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAV header parser testbench
// Streams whole WAV files into the parser: a set of hand-built files for the
// tag, format, error and end-of-file cases, then random files, most of them
// well formed, the rest cut short, corrupted or plain noise. Both sides of
// the block idle at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import wavhp_pkg::*;

	localparam int          CLK_HALF     = 4;
	localparam int          RESET_CYCLES = 11;
	localparam int          TOTAL_BYTES  = 750;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          DRAIN_CYCLES = 16;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam logic [31:0] TAG_RIFX     = 32'h5249_4658;
	localparam logic [31:0] TAG_WAVF     = 32'h5741_5646;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tlast;
	logic [1:0]         m_tuser;

	int                 pending_results;
	int                 mismatch_count;
	int                 sent_bytes;
	int                 cycle_count;
	int                 hold_count;
	bit                 steady       = 1'b0;
	bit                 hold_request = 1'b0;
	logic [7:0]         file_q[$];

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	wav_header_parser i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	wav_stream_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.m_tuser         (m_tuser),
		.pending_results (pending_results),
		.mismatch_count  (mismatch_count)
	);

	// Tags travel most significant byte first, lengths and fields little-endian.
	task automatic add_tag(input logic [31:0] tag);
		for (int i = 3; i >= 0; i--)
			file_q.push_back(tag[8*i +: 8]);
	endtask

	task automatic add_le(input logic [31:0] value, input int count);
		for (int i = 0; i < count; i++)
			file_q.push_back(value[8*i +: 8]);
	endtask

	task automatic add_random(input int count);
		for (int i = 0; i < count; i++)
			file_q.push_back(8'($urandom));
	endtask

	task automatic add_riff();
		add_tag(TAG_RIFF);
		add_random(4);
		add_tag(TAG_WAVE);
	endtask

	task automatic add_chunk(input logic [31:0] tag, input int len);
		add_tag(tag);
		add_le(len, 4);
		add_random(len + len % 2);
	endtask

	task automatic add_fmt(input int len, input logic [15:0] coding,
	                       input logic [15:0] channels, input logic [31:0] rate,
	                       input logic [15:0] bits);
		logic [127:0] body;
		// Byte rate and block alignment are not looked at, so they are random.
		body = {bits, $urandom, 16'($urandom), rate, channels, coding};
		add_tag(TAG_FMT);
		add_le(len, 4);
		for (int i = 0; i < len; i++)
			file_q.push_back(i < 16 ? body[8*i +: 8] : 8'($urandom));
		if (len % 2 != 0)
			add_random(1);
	endtask

	task automatic add_data(input logic [31:0] len, input int payload);
		add_tag(TAG_DATA);
		add_le(len, 4);
		add_random(payload);
	endtask

	task automatic add_random_fmt();
		logic [15:0] coding;
		logic [15:0] bits;
		logic [15:0] channels;
		logic [31:0] rate;
		int          len;
		case ($urandom_range(5))
			0: begin
				coding = FMT_TAG_FLOAT;
				bits   = 16'd32;
			end
			1, 2: begin
				coding = FMT_TAG_PCM;
				bits   = 16'd16;
			end
			3: begin
				coding = FMT_TAG_PCM;
				bits   = 16'd8;
			end
			4: begin
				coding = FMT_TAG_PCM;
				bits   = 16'd32;
			end
			default: begin
				coding = $urandom_range(1) ? 16'($urandom) :
				         ($urandom_range(1) ? FMT_TAG_PCM : FMT_TAG_FLOAT);
				bits   = $urandom_range(1) ? 16'($urandom) : 16'(8 << $urandom_range(2));
			end
		endcase
		case ($urandom_range(9))
			0: channels = '0;
			1: channels = 16'($urandom);
			default: channels = 16'($urandom_range(1, 8));
		endcase
		case ($urandom_range(9))
			0: rate = '0;
			1: rate = 32'h8000_0000 | $urandom;
			2: rate = $urandom;
			default: rate = $urandom_range(8000, 192000);
		endcase
		case ($urandom_range(9))
			0: len = $urandom_range(0, 15);
			1, 2: len = $urandom_range(17, 24);
			default: len = 16;
		endcase
		add_fmt(len, coding, channels, rate, bits);
	endtask

	task automatic add_random_wave();
		int          n_other;
		int          fmt_slot;
		int          payload;
		logic [31:0] data_len;
		add_riff();
		n_other  = $urandom_range(0, 2);
		fmt_slot = $urandom_range(0, n_other);
		for (int c = 0; c <= n_other; c++) begin
			if (c == fmt_slot && $urandom_range(19) != 0)
				add_random_fmt();
			if (c < n_other) begin
				// Now and then an extra fmt chunk; of two of 16 bytes or more, the later one counts.
				if ($urandom_range(9) == 0)
					add_random_fmt();
				else
					add_chunk($urandom, $urandom_range(0, 9));
			end
		end
		data_len = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 12);
		payload  = (data_len > 12) ? $urandom_range(0, 12) : int'(data_len);
		if ($urandom_range(4) == 0)
			payload = $urandom_range(0, payload);
		add_data(data_len, payload);
		if ($urandom_range(1))
			add_random($urandom_range(1, 3));
	endtask

	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++) begin
			while (!steady && $urandom_range(99) < 33) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= file_q[i];
			s_tlast  <= (i == file_q.size() - 1);
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
		end
		sent_bytes += file_q.size();
		file_q.delete();
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	// Receiver: random stalls, one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
					m_tready <= 1'b0;
					@(posedge clk);
				end
			end
			m_tready <= steady || ($urandom_range(99) >= 33);
		end
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int pick;
		int cut;
		int pos;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		sent_bytes = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Plain 16-bit file with bytes after the payload, which must be ignored.
		add_riff();
		add_fmt(16, FMT_TAG_PCM, 2, 44100, 16);
		add_data(4, 4);
		add_random(3);
		send_file();
		// Float file with an empty data chunk.
		add_riff();
		add_fmt(16, FMT_TAG_FLOAT, 1, 48000, 32);
		add_data(0, 0);
		add_random(2);
		send_file();
		// Odd chunk with its pad byte, long fmt, payload cut by the end of file.
		add_riff();
		add_chunk(32'h4C49_5354, 3);
		add_fmt(18, FMT_TAG_PCM, 1, 8000, 8);
		add_data(3, 1);
		send_file();
		// Widest accepted fields, file ends on the last byte of the data header.
		add_riff();
		add_fmt(17, FMT_TAG_PCM, 16'hFFFF, 32'h7FFF_FFFF, 32);
		add_data(5, 0);
		send_file();
		// Bad RIFF tag, the rest of the file is ignored.
		add_tag(TAG_RIFX);
		add_random(5);
		send_file();
		// Bad WAVE tag.
		add_tag(TAG_RIFF);
		add_random(4);
		add_tag(TAG_WAVF);
		add_random(2);
		send_file();
		// Data before any fmt, and the file ends on the data header.
		add_riff();
		add_data(8, 0);
		send_file();
		// A short fmt chunk is not kept.
		add_riff();
		add_fmt(14, FMT_TAG_PCM, 2, 44100, 16);
		add_data(2, 2);
		send_file();
		// Unsupported coding.
		add_riff();
		add_fmt(16, 16'd2, 1, 22050, 16);
		add_data(2, 2);
		send_file();
		// Zero channels, zero rate, rate with the top bit set.
		add_riff();
		add_fmt(16, FMT_TAG_PCM, 0, 44100, 16);
		add_data(2, 2);
		send_file();
		add_riff();
		add_fmt(16, FMT_TAG_FLOAT, 2, 0, 32);
		add_data(2, 2);
		send_file();
		add_riff();
		add_fmt(16, FMT_TAG_PCM, 1, 32'h8000_0000, 8);
		add_data(2, 2);
		send_file();
		// Bad coding and zero channels together: the coding error wins.
		add_riff();
		add_fmt(16, FMT_TAG_FLOAT, 0, 44100, 8);
		add_data(2, 2);
		send_file();
		// Two fmt chunks: only the later one counts.
		add_riff();
		add_fmt(16, 16'd7, 1, 8000, 8);
		add_fmt(16, FMT_TAG_PCM, 6, 96000, 32);
		add_data(2, 2);
		send_file();
		// File ends inside a chunk header.
		add_riff();
		add_fmt(16, FMT_TAG_PCM, 2, 44100, 16);
		add_random(3);
		send_file();
		// One-byte file, and a four-byte file whose final byte fails the tag.
		file_q.push_back(8'h52);
		send_file();
		add_tag(TAG_RIFX);
		send_file();
		// Payload bytes at both extremes.
		add_riff();
		add_fmt(16, FMT_TAG_PCM, 1, 16000, 8);
		add_data(2, 0);
		file_q.push_back(8'h00);
		file_q.push_back(8'hFF);
		send_file();

		// Sender pauses until every outstanding result has been taken.
		wait_for_results();

		for (int f = 0; f < 3 || sent_bytes < TOTAL_BYTES; f++) begin
			steady = (f >= 1 && f < 3);
			if (f == 0)
				hold_request = 1'b1;
			pick = $urandom_range(99);
			if (pick < 70)
				add_random_wave();
			else if (pick < 88) begin
				add_random_wave();
				if ($urandom_range(1)) begin
					cut = $urandom_range(1, file_q.size());
					while (file_q.size() > cut)
						file_q.delete(file_q.size() - 1);
				end else begin
					pos         = $urandom_range(0, file_q.size() - 1);
					file_q[pos] = file_q[pos] ^ (8'd1 << $urandom_range(7));
				end
			end else begin
				if ($urandom_range(1))
					add_tag(TAG_RIFF);
				add_random($urandom_range(1, 12));
			end
			send_file();
		end
		steady = 1'b0;

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
